### rtl/core/ssid_pkg.sv
// Shared types and constants for the sorted set insert/delete core.
package ssid_pkg;

	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned COUNT_W     = 6;
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	typedef struct packed {
		logic                       kind;
		logic signed [VALUE_W-1:0]  value;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0]         count;
		logic signed [VALUE_W-1:0]  element;
		logic                       element_valid;
		logic                       last;
		logic                       dropped_full;
	} result_t;

	typedef struct packed {
		op_t                        op;
		logic signed [VALUE_W-1:0]  value;
	} job_t;

endpackage

### rtl/core/ssid_front.sv
// Front end: accepts transactions, decodes the operation and queues jobs.
module ssid_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  ssid_pkg::item_t item,
	output logic            job_valid,
	input  logic            job_ready,
	output ssid_pkg::job_t  job
);
	import ssid_pkg::*;

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned OW = $clog2(QUEUE_DEPTH + 1);

	job_t            queue_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [OW-1:0]   occ_q;
	logic            push;
	logic            pop;
	job_t            decoded;

	assign item_ready = (occ_q != OW'(QUEUE_DEPTH));
	assign job_valid  = (occ_q != '0);
	assign job        = queue_q[rd_ptr_q];
	assign push       = item_valid && item_ready;
	assign pop        = job_valid && job_ready;

	always_comb begin
		decoded.op    = item.kind ? OP_DELETE : OP_INSERT;
		decoded.value = item.value;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   occ_q <= occ_q + 1'b1;
				2'b01:   occ_q <= occ_q - 1'b1;
				default: occ_q <= occ_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OW'(QUEUE_DEPTH))
		else $error("queue occupancy exceeds depth");
`endif

endmodule

### rtl/core/ssid_back.sv
// Back end: searches, updates the sorted store and streams out the contents.
module ssid_back #(
	parameter int unsigned CAPACITY = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  ssid_pkg::job_t    job,
	output logic              result_valid,
	input  logic              result_ready,
	output ssid_pkg::result_t result
);
	import ssid_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned AW = $clog2(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRD,
		S_SCMP,
		S_DEC,
		S_ERD,
		S_EMIT,
		S_EMPTY
	} state_t;

	state_t                     state_q;
	job_t                       job_q;
	logic [CW-1:0]              cnt_q;
	logic [CW-1:0]              j_q;
	logic [CW-1:0]              pos_q;
	logic [CW-1:0]              o_q;
	logic                       present_q;
	logic                       ins_q;
	logic                       del_q;
	logic                       drop_q;
	logic signed [VALUE_W-1:0]  carry_q;
	logic signed [VALUE_W-1:0]  rdata_q;
	logic signed [VALUE_W-1:0]  mem [CAPACITY];
	logic                       result_valid_q;
	result_t                    result_q;

	logic                       out_free;
	logic [AW-1:0]              mem_ra;
	logic                       mem_we;
	logic signed [VALUE_W-1:0]  emit_val;
	logic                       emit_last;
	logic                       is_full;
	logic                       dec_ins;
	logic                       dec_del;
	logic                       dec_drop;
	logic [CW-1:0]              cnt_new;

	assign job_ready    = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || result_ready;
	assign is_full      = (cnt_q == CW'(CAPACITY));
	assign emit_last    = (o_q == cnt_q - 1'b1);
	assign mem_we       = (state_q == S_EMIT) && out_free;

	always_comb begin
		dec_ins  = (job_q.op == OP_INSERT) && !present_q && !is_full;
		dec_drop = (job_q.op == OP_INSERT) && !present_q && is_full;
		dec_del  = (job_q.op == OP_DELETE) && present_q;
		cnt_new  = cnt_q + CW'(dec_ins) - CW'(dec_del);
	end

	always_comb begin
		unique case (state_q)
			S_ERD, S_EMIT: mem_ra = (del_q && (o_q >= pos_q)) ? AW'(o_q + 1'b1) : o_q[AW-1:0];
			default:       mem_ra = j_q[AW-1:0];
		endcase
	end

	always_comb begin
		priority if (ins_q && (o_q == pos_q)) begin
			emit_val = job_q.value;
		end else if (ins_q && (o_q > pos_q)) begin
			emit_val = carry_q;
		end else begin
			emit_val = rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[o_q[AW-1:0]] <= emit_val;
		end
		rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						job_q   <= job;
						j_q     <= '0;
						state_q <= S_SRD;
					end
				end
				S_SRD: begin
					if (j_q == cnt_q) begin
						pos_q     <= j_q;
						present_q <= 1'b0;
						state_q   <= S_DEC;
					end else begin
						state_q <= S_SCMP;
					end
				end
				S_SCMP: begin
					if (rdata_q >= job_q.value) begin
						pos_q     <= j_q;
						present_q <= (rdata_q == job_q.value);
						state_q   <= S_DEC;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_SRD;
					end
				end
				S_DEC: begin
					ins_q   <= dec_ins;
					del_q   <= dec_del;
					drop_q  <= dec_drop;
					cnt_q   <= cnt_new;
					o_q     <= '0;
					state_q <= (cnt_new == '0) ? S_EMPTY : S_ERD;
				end
				S_ERD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						result_valid_q         <= 1'b1;
						result_q.count         <= COUNT_W'(cnt_q);
						result_q.element       <= emit_val;
						result_q.element_valid <= 1'b1;
						result_q.last          <= emit_last;
						result_q.dropped_full  <= drop_q;
						carry_q                <= rdata_q;
						if (emit_last) begin
							state_q <= S_IDLE;
						end else begin
							o_q     <= o_q + 1'b1;
							state_q <= S_ERD;
						end
					end
				end
				S_EMPTY: begin
					if (out_free) begin
						result_valid_q         <= 1'b1;
						result_q.count         <= '0;
						result_q.element       <= '0;
						result_q.element_valid <= 1'b0;
						result_q.last          <= 1'b1;
						result_q.dropped_full  <= drop_q;
						state_q                <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_q.element_valid) |->
			(result_q.count == '0) && result_q.last && !result_q.dropped_full)
		else $error("empty-set result malformed");
`endif

endmodule

### rtl/core/sorted_set_insert_delete_core.sv
// Top level of the sorted set insert/delete core.
//
//  channel  direction  handshake                    payload
//  item     in         item_valid / item_ready      ssid_pkg::item_t   (kind, value)
//  result   out        result_valid / result_ready  ssid_pkg::result_t (count, element, ...)
//
// A transaction holds the back end through a linear search up to the insertion point and a
// pass that reads, rewrites and streams out every resulting entry; the store has a single
// read port with a registered read.
// The result stream has one result per stored element, or one result if the set is empty.
// A result that waits for result_ready stalls the back end.
// Reset clears the count and the job queue; the store needs no clearing.
// Up to two transactions queue in front while the back end works or the result stalls.
module sorted_set_insert_delete_core #(
	parameter int unsigned CAPACITY = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  ssid_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output ssid_pkg::result_t result
);
	import ssid_pkg::*;

	logic job_valid;
	logic job_ready;
	job_t job;

	ssid_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.job_valid  (job_valid),
		.job_ready  (job_ready),
		.job        (job)
	);

	ssid_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job_ready    (job_ready),
		.job          (job),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
